>>> src/crcfr_pkg.sv
// package for the crc16 frame receiver: codes, types and crc byte update
`default_nettype none
package crcfr_pkg;

  localparam logic [7:0]  SYNC_BYTE  = 8'hFF;
  localparam logic [15:0] CRC_POLY   = 16'h1021;
  localparam logic [7:0]  LEN_OFFSET = 8'd5;

  localparam logic [1:0] EV_PAYLOAD = 2'd0;
  localparam logic [1:0] EV_ACCEPT  = 2'd1;
  localparam logic [1:0] EV_REJECT  = 2'd2;

  // word held in the input register
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } s1_word_t;

  // one msb-first crc step over a byte, eight shift/xor steps on 16 bits
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

>>> src/crc16_frame_receiver.sv
// top level of the crc16 framed byte receiver
//
//  channel  direction  handshake            word
//  in_      input      in_valid/in_ready    rx_byte
//  out_     output     out_valid/out_ready  event_kind .. computed_crc
//
// one word a cycle unless a result waits on a stalled output: input register,
// then one crc byte step and the frame parser into the result register, so a
// result is registered as its word leaves the input register. reset is
// synchronous and clears all frame state to sync hunting. words that yield no
// result keep flowing under an output stall; a word that yields a result waits
// in the input register until the result register frees up.
`default_nettype none
module crc16_frame_receiver
  import crcfr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_event_kind,
  output logic [7:0]       out_frame_type,
  output logic [7:0]       out_payload_index,
  output logic [7:0]       out_payload_byte,
  output logic [7:0]       out_payload_count,
  output logic [15:0]      out_received_crc,
  output logic [15:0]      out_computed_crc
);

  s1_word_t s1;
  logic     s1_take;

  crcfr_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .s1         (s1),
    .s1_take    (s1_take)
  );

  crcfr_core u_core (
    .clk               (clk),
    .rst_n             (rst_n),
    .s1                (s1),
    .s1_take           (s1_take),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_event_kind    (out_event_kind),
    .out_frame_type    (out_frame_type),
    .out_payload_index (out_payload_index),
    .out_payload_byte  (out_payload_byte),
    .out_payload_count (out_payload_count),
    .out_received_crc  (out_received_crc),
    .out_computed_crc  (out_computed_crc)
  );

endmodule
`default_nettype wire

>>> src/crcfr_in_reg.sv
// input register stage: holds one received word ahead of the frame core
`default_nettype none
module crcfr_in_reg
  import crcfr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_rx_byte,
  output s1_word_t        s1,
  input  wire logic       s1_take
);

  logic       valid_r;
  logic [7:0] data_r;

  assign in_ready = !valid_r || s1_take;
  assign s1.valid = valid_r;
  assign s1.data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_rx_byte;
    end
  end

endmodule
`default_nettype wire

>>> src/crcfr_core.sv
// frame parser, crc accumulator and result register
`default_nettype none
module crcfr_core
  import crcfr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire s1_word_t    s1,
  output logic             s1_take,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_event_kind,
  output logic [7:0]       out_frame_type,
  output logic [7:0]       out_payload_index,
  output logic [7:0]       out_payload_byte,
  output logic [7:0]       out_payload_count,
  output logic [15:0]      out_received_crc,
  output logic [15:0]      out_computed_crc
);

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_TYPE = 3'd1,
    PH_LEN  = 3'd2,
    PH_PAY  = 3'd3,
    PH_CRCH = 3'd4,
    PH_CRCL = 3'd5
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [7:0]  left_r, left_nxt;
  logic [7:0]  index_r, index_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  crch_r, crch_nxt;

  logic        out_valid_r;
  logic [1:0]  kind_r, kind_nxt;
  logic [7:0]  otype_r, otype_nxt;
  logic [7:0]  oidx_r, oidx_nxt;
  logic [7:0]  obyte_r, obyte_nxt;
  logic [7:0]  ocnt_r, ocnt_nxt;
  logic [15:0] orx_r, orx_nxt;
  logic [15:0] ocrc_r, ocrc_nxt;

  logic        has_res;
  logic [7:0]  b;
  logic [7:0]  len_b;
  logic [15:0] rx_crc;

  assign b       = s1.data;
  assign has_res = (phase_r == PH_PAY) || (phase_r == PH_CRCL);
  // a word that yields no result never waits on the output side
  assign s1_take = s1.valid && (!has_res || !out_valid_r || out_ready);
  assign len_b   = (b >= LEN_OFFSET) ? b : LEN_OFFSET;
  assign rx_crc  = {crch_r, b};

  always_comb begin
    phase_nxt = phase_r;
    type_nxt  = type_r;
    left_nxt  = left_r;
    index_nxt = index_r;
    crc_nxt   = crc_r;
    crch_nxt  = crch_r;
    kind_nxt  = EV_PAYLOAD;
    otype_nxt = type_r;
    oidx_nxt  = 8'd0;
    obyte_nxt = 8'd0;
    ocnt_nxt  = 8'd0;
    orx_nxt   = 16'd0;
    ocrc_nxt  = 16'd0;
    case (phase_r)
      PH_TYPE: begin
        type_nxt  = b;
        crc_nxt   = crc_byte(crc_r, b);
        phase_nxt = PH_LEN;
      end
      PH_LEN: begin
        left_nxt  = len_b - LEN_OFFSET;
        crc_nxt   = crc_byte(crc_r, len_b);
        index_nxt = 8'd0;
        phase_nxt = (len_b != LEN_OFFSET) ? PH_PAY : PH_CRCH;
      end
      PH_PAY: begin
        crc_nxt   = crc_byte(crc_r, b);
        kind_nxt  = EV_PAYLOAD;
        oidx_nxt  = index_r;
        obyte_nxt = b;
        ocnt_nxt  = index_r + left_r;
        index_nxt = index_r + 8'd1;
        left_nxt  = left_r - 8'd1;
        if (left_r == 8'd1) begin
          phase_nxt = PH_CRCH;
        end
      end
      PH_CRCH: begin
        crch_nxt  = b;
        phase_nxt = PH_CRCL;
      end
      PH_CRCL: begin
        kind_nxt  = (rx_crc == crc_r) ? EV_ACCEPT : EV_REJECT;
        ocnt_nxt  = index_r;
        orx_nxt   = rx_crc;
        ocrc_nxt  = crc_r;
        phase_nxt = PH_HUNT;
      end
      default: begin
        phase_nxt = PH_HUNT;
        if (b == SYNC_BYTE) begin
          crc_nxt   = crc_byte(16'd0, b);
          phase_nxt = PH_TYPE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      type_r      <= 8'd0;
      left_r      <= 8'd0;
      index_r     <= 8'd0;
      crc_r       <= 16'd0;
      crch_r      <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_take) begin
        phase_r <= phase_nxt;
        type_r  <= type_nxt;
        left_r  <= left_nxt;
        index_r <= index_nxt;
        crc_r   <= crc_nxt;
        crch_r  <= crch_nxt;
      end
      if (s1_take && has_res) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take && has_res) begin
      kind_r  <= kind_nxt;
      otype_r <= otype_nxt;
      oidx_r  <= oidx_nxt;
      obyte_r <= obyte_nxt;
      ocnt_r  <= ocnt_nxt;
      orx_r   <= orx_nxt;
      ocrc_r  <= ocrc_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_event_kind    = kind_r;
  assign out_frame_type    = otype_r;
  assign out_payload_index = oidx_r;
  assign out_payload_byte  = obyte_r;
  assign out_payload_count = ocnt_r;
  assign out_received_crc  = orx_r;
  assign out_computed_crc  = ocrc_r;

  // payload phase always has bytes left to take
  a_pay_left: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PAY) |-> (left_r != 8'd0))
    else $error("payload phase with no bytes left");

  // end of frame goes back to hunting and posts an end event
  a_crcl_end: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_take && phase_r == PH_CRCL) |=>
      (phase_r == PH_HUNT && out_valid_r && kind_r != EV_PAYLOAD))
    else $error("frame end did not post an end event");

  // a result held under stall is never overwritten
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !(s1_take && has_res))
    else $error("result register overwritten while stalled");

  // payload index stays in step with the count of payload words
  a_pay_count: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_take && phase_r == PH_PAY) |=> (out_payload_index == $past(index_r)))
    else $error("payload index out of step");

endmodule
`default_nettype wire

>>> tb/crcfr_checker.sv
// checker for the crc16 frame receiver: predicts events from accepted words and compares them
`timescale 1ns / 100ps
module crcfr_checker
  import crcfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_event_kind,
  input  logic [7:0]  out_frame_type,
  input  logic [7:0]  out_payload_index,
  input  logic [7:0]  out_payload_byte,
  input  logic [7:0]  out_payload_count,
  input  logic [15:0] out_received_crc,
  input  logic [15:0] out_computed_crc,
  output int          errors,
  output int          pending
);

  typedef enum logic [2:0] {
    HUNT         = 3'd0,
    TAKE_TYPE    = 3'd1,
    TAKE_LEN     = 3'd2,
    TAKE_PAYLOAD = 3'd3,
    TAKE_CRC_HI  = 3'd4,
    TAKE_CRC_LO  = 3'd5
  } rx_phase_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  ftype;
    logic [7:0]  index;
    logic [7:0]  data;
    logic [7:0]  count;
    logic [15:0] rx_crc;
    logic [15:0] calc_crc;
  } rx_event_t;

  rx_event_t   due_events[$];
  rx_phase_t   phase;
  logic [7:0]  ftype;
  logic [7:0]  left;
  logic [7:0]  index;
  logic [7:0]  crc_hi;
  logic [15:0] crc;
  int          fail_count;

  assign errors  = fail_count;
  assign pending = due_events.size();

  // msb first, one bit of the byte per shift
  function automatic logic [15:0] crc16_shift_in(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = acc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ b[i];
      r = {r[14:0], 1'b0};
      if (fb) begin
        r = r ^ CRC_POLY;
      end
    end
    return r;
  endfunction

  task automatic parse_rx_byte(input logic [7:0] b);
    rx_event_t  ev;
    logic [7:0] len_used;
    ev = '0;
    case (phase)
      TAKE_TYPE: begin
        ftype = b;
        crc = crc16_shift_in(crc, b);
        phase = TAKE_LEN;
      end
      TAKE_LEN: begin
        // a short length counts as the minimum in the crc
        len_used = (b < LEN_OFFSET) ? LEN_OFFSET : b;
        left = len_used - LEN_OFFSET;
        crc = crc16_shift_in(crc, len_used);
        index = 8'd0;
        phase = (left != 8'd0) ? TAKE_PAYLOAD : TAKE_CRC_HI;
      end
      TAKE_PAYLOAD: begin
        crc = crc16_shift_in(crc, b);
        ev.kind = EV_PAYLOAD;
        ev.ftype = ftype;
        ev.index = index;
        ev.data = b;
        ev.count = index + left;
        due_events.push_back(ev);
        index = index + 8'd1;
        left = left - 8'd1;
        if (left == 8'd0) begin
          phase = TAKE_CRC_HI;
        end
      end
      TAKE_CRC_HI: begin
        crc_hi = b;
        phase = TAKE_CRC_LO;
      end
      TAKE_CRC_LO: begin
        ev.rx_crc = {crc_hi, b};
        ev.calc_crc = crc;
        ev.kind = (ev.rx_crc == crc) ? EV_ACCEPT : EV_REJECT;
        ev.ftype = ftype;
        ev.count = index;
        due_events.push_back(ev);
        phase = HUNT;
      end
      default: begin
        phase = HUNT;
        if (b == SYNC_BYTE) begin
          crc = crc16_shift_in(16'h0000, b);
          phase = TAKE_TYPE;
        end
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      phase = HUNT;
      ftype = 8'd0;
      left = 8'd0;
      index = 8'd0;
      crc_hi = 8'd0;
      crc = 16'd0;
      due_events.delete();
    end else begin
      // results always trail their word, so retire before predicting
      if (out_valid && out_ready) begin
        if (due_events.size() == 0) begin
          $display("%0t: unexpected event, expected none actual kind %h type %h idx %h byte %h",
                   $time, out_event_kind, out_frame_type, out_payload_index, out_payload_byte);
          fail_count++;
        end else begin
          rx_event_t want;
          want = due_events.pop_front();
          check_field("event_kind", 16'(want.kind), 16'(out_event_kind));
          check_field("frame_type", 16'(want.ftype), 16'(out_frame_type));
          check_field("payload_index", 16'(want.index), 16'(out_payload_index));
          check_field("payload_byte", 16'(want.data), 16'(out_payload_byte));
          check_field("payload_count", 16'(want.count), 16'(out_payload_count));
          check_field("received_crc", want.rx_crc, out_received_crc);
          check_field("computed_crc", want.calc_crc, out_computed_crc);
        end
      end
      if (in_valid && in_ready) begin
        parse_rx_byte(in_rx_byte);
      end
    end
  end

endmodule

>>> tb/tb.sv
// testbench top for the crc16 frame receiver: framed byte traffic, handshake pressure, verdict
`timescale 1ns / 100ps
module tb;
  import crcfr_pkg::*;

  localparam int STALL_LIMIT = 2000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_event_kind;
  logic [7:0]  out_frame_type;
  logic [7:0]  out_payload_index;
  logic [7:0]  out_payload_byte;
  logic [7:0]  out_payload_count;
  logic [15:0] out_received_crc;
  logic [15:0] out_computed_crc;
  int          errors;
  int          pending;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          frame_bytes;
  int          stall_cycles;

  crc16_frame_receiver DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_event_kind    (out_event_kind),
    .out_frame_type    (out_frame_type),
    .out_payload_index (out_payload_index),
    .out_payload_byte  (out_payload_byte),
    .out_payload_count (out_payload_count),
    .out_received_crc  (out_received_crc),
    .out_computed_crc  (out_computed_crc)
  );

  crcfr_checker chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_event_kind    (out_event_kind),
    .out_frame_type    (out_frame_type),
    .out_payload_index (out_payload_index),
    .out_payload_byte  (out_payload_byte),
    .out_payload_count (out_payload_count),
    .out_received_crc  (out_received_crc),
    .out_computed_crc  (out_computed_crc),
    .errors            (errors),
    .pending           (pending)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // fill below zero gives random payload, otherwise every payload word is fill
  task automatic send_frame(input logic [7:0] ftype, input logic [7:0] len, input int fill,
                            input bit corrupt);
    logic [15:0] crc;
    logic [7:0]  len_used;
    logic [7:0]  b;
    int          n;
    crc = crc_byte(16'h0000, SYNC_BYTE);
    send_byte(SYNC_BYTE);
    crc = crc_byte(crc, ftype);
    send_byte(ftype);
    len_used = (len < LEN_OFFSET) ? LEN_OFFSET : len;
    crc = crc_byte(crc, len_used);
    send_byte(len);
    n = int'(len_used - LEN_OFFSET);
    for (int i = 0; i < n; i++) begin
      b = (fill < 0) ? 8'($urandom_range(255)) : 8'(fill);
      crc = crc_byte(crc, b);
      send_byte(b);
    end
    if (corrupt) begin
      crc = crc ^ 16'($urandom_range(65535, 1));
    end
    send_byte(crc[15:8]);
    send_byte(crc[7:0]);
    frame_bytes += n + 5;
  endtask

  task automatic run_traffic(input int n_items);
    int         start;
    int         pick;
    logic [7:0] len;
    start = frame_bytes;
    while (frame_bytes - start < n_items) begin
      pick = $urandom_range(99);
      if (pick < 15) begin
        // line noise, never a sync word
        repeat ($urandom_range(4, 1)) send_byte(8'($urandom_range(254)));
      end else if (pick < 17) begin
        // stray sync swallows the start of the next frame
        send_byte(SYNC_BYTE);
      end
      pick = $urandom_range(99);
      if (pick < 15) begin
        len = 8'($urandom_range(4));
      end else if (pick < 75) begin
        len = 8'($urandom_range(20, 5));
      end else if (pick < 95) begin
        len = 8'($urandom_range(100, 21));
      end else begin
        len = 8'($urandom_range(255, 200));
      end
      send_frame(8'($urandom_range(255)), len, -1, $urandom_range(99) < 15);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_rx_byte = 8'h00;
    out_ready = 1'b0;
    stall_cycles = 0;
    frame_bytes = 0;
    send_idle_pct = 6;
    recv_idle_pct = 85;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // words while hunting for sync
    send_byte(8'h00);
    send_byte(8'h7F);
    send_byte(8'hFE);
    // short lengths, good and bad check
    send_frame(8'hFF, 8'h00, -1, 1'b0);
    send_frame(8'h00, 8'h04, -1, 1'b1);
    // minimum length, empty payload
    send_frame(8'hA5, 8'h05, -1, 1'b0);
    // sync words inside the payload are data
    send_frame(8'h5A, 8'h07, 8'hFF, 1'b0);

    run_traffic(617);
    drain();
    send_idle_pct = 85;
    recv_idle_pct = 6;
    run_traffic(617);
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_traffic(616);
    drain();

    if (errors == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> sim.f
src/crcfr_pkg.sv
src/crcfr_in_reg.sv
src/crcfr_core.sv
src/crc16_frame_receiver.sv
tb/crcfr_checker.sv
tb/tb.sv
